// ----- hw/rtl/symbol_table_floor_lookup_defines.svh -----
// Assertion macros used by the checker of this block.
`ifndef SYMBOL_TABLE_FLOOR_LOOKUP_DEFINES_SVH
`define SYMBOL_TABLE_FLOOR_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STFL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stfl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STFL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stfl assertion failed");

`endif

// ----- hw/rtl/stfl_pkg.sv -----
package stfl_pkg;

  // Table geometry
  localparam int unsigned DEPTH     = 128;
  localparam int unsigned TAG_WIDTH = 32;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned IN_TAG_W  = 32;
  localparam int unsigned RES_TAG_W = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // Stream beat layout
  localparam int unsigned IN_DATA_W      = 96;
  localparam int unsigned IN_ADDR_LSB    = 0;
  localparam int unsigned IN_TAG_LSB     = 64;
  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_TAG_LSB    = 2;
  localparam int unsigned OUT_COUNT_LSB  = 34;
  localparam int unsigned OUT_USED_W     = 42;
  localparam int unsigned OUT_DATA_W     = 48;

  // Action codes
  localparam logic ACT_REG    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOENT = 2'd3
  } status_e;

  typedef struct packed {
    logic                action;
    logic [ADDR_W-1:0]   address;
    logic [IN_TAG_W-1:0] name_tag;
  } item_t;

  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [ADDR_W-1:0]    wr_addr;
    logic [TAG_WIDTH-1:0] wr_tag;
  } mem_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic [RES_TAG_W-1:0] found_tag;
    logic [COUNT_W-1:0]   entry_count;
  } result_t;

endpackage

// ----- hw/rtl/stfl_mem.sv -----
module stfl_mem (
  input  logic              clk_i,
  input  stfl_pkg::mem_req_t req_i,
  output stfl_pkg::entry_t  rdata_o
);

  logic [stfl_pkg::ADDR_W-1:0]    addr_mem [stfl_pkg::DEPTH];
  logic [stfl_pkg::TAG_WIDTH-1:0] tag_mem  [stfl_pkg::DEPTH];
  stfl_pkg::entry_t               rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      addr_mem[req_i.wr_idx] <= req_i.wr_addr;
      tag_mem[req_i.wr_idx]  <= req_i.wr_tag;
    end
  end

  // Single registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q.addr <= addr_mem[req_i.rd_idx];
      rdata_q.tag  <= tag_mem[req_i.rd_idx];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/stfl_seq.sv -----
module stfl_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stfl_pkg::item_t    item_i,
  output logic               res_valid_o,
  input  logic               out_free_i,
  output stfl_pkg::result_t  res_o,
  output stfl_pkg::mem_req_t mem_req_o,
  input  stfl_pkg::entry_t   mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic                           act_q, act_d;
  logic [stfl_pkg::ADDR_W-1:0]    key_q, key_d;
  logic [stfl_pkg::TAG_WIDTH-1:0] tag_q, tag_d;
  logic [stfl_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [stfl_pkg::CNT_W-1:0]     fill_q, fill_d;
  logic                           rvld_q, rvld_d;
  logic [stfl_pkg::IDX_W-1:0]     ridx_q, ridx_d;
  logic                           have_q, have_d;
  logic                           hit_q, hit_d;
  logic [stfl_pkg::IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [stfl_pkg::ADDR_W-1:0]    best_addr_q, best_addr_d;
  logic [stfl_pkg::TAG_WIDTH-1:0] best_tag_q, best_tag_d;
  stfl_pkg::status_e              status_q, status_d;

  logic                           rd_go;
  logic                           cmp_eq, cmp_le, cmp_gt;
  logic [stfl_pkg::TAG_WIDTH-1:0] in_tag;

  // Shared compare unit: entry read last cycle against key and best so far
  assign cmp_eq = (mem_rdata_i.addr == key_q);
  assign cmp_le = (mem_rdata_i.addr <= key_q);
  assign cmp_gt = (mem_rdata_i.addr > best_addr_q);

  assign in_tag = stfl_pkg::TAG_WIDTH'(item_i.name_tag);
  assign rd_go  = (state_q == S_SCAN) && (idx_q < fill_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    key_d       = key_q;
    tag_d       = tag_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    rvld_d      = 1'b0;
    ridx_d      = ridx_q;
    have_d      = have_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    best_addr_d = best_addr_q;
    best_tag_d  = best_tag_q;
    status_d    = status_q;
    mem_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d  = item_i.action;
          key_d  = item_i.address;
          tag_d  = in_tag;
          idx_d  = '0;
          have_d = 1'b0;
          hit_d  = 1'b0;
          if ((item_i.address == '0) ||
              ((item_i.action == stfl_pkg::ACT_REG) && (in_tag == '0))) begin
            status_d = stfl_pkg::ST_INVAL;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, compared in the next cycle
        mem_req_o.rd_en  = rd_go;
        mem_req_o.rd_idx = idx_q[stfl_pkg::IDX_W-1:0];
        rvld_d           = rd_go;
        ridx_d           = idx_q[stfl_pkg::IDX_W-1:0];
        if (rd_go) begin
          idx_d = idx_q + stfl_pkg::CNT_W'(1);
        end
        if (rvld_q) begin
          if (act_q == stfl_pkg::ACT_REG) begin
            if (cmp_eq) begin
              hit_d     = 1'b1;
              hit_idx_d = ridx_q;
              status_d  = stfl_pkg::ST_OK;
              rvld_d    = 1'b0;
              state_d   = S_DONE;
            end
          end else if (cmp_le && (!have_q || cmp_gt)) begin
            have_d      = 1'b1;
            best_addr_d = mem_rdata_i.addr;
            best_tag_d  = mem_rdata_i.tag;
          end
        end else if (!rd_go) begin
          state_d = S_DONE;
          if (act_q == stfl_pkg::ACT_REG) begin
            status_d = (fill_q == stfl_pkg::CNT_W'(stfl_pkg::DEPTH)) ?
                       stfl_pkg::ST_FULL : stfl_pkg::ST_OK;
          end else begin
            status_d = have_q ? stfl_pkg::ST_OK : stfl_pkg::ST_NOENT;
          end
        end
      end
      S_DONE: begin
        // commit the table update as the result leaves
        if (out_free_i) begin
          state_d = S_IDLE;
          if ((act_q == stfl_pkg::ACT_REG) && (status_q == stfl_pkg::ST_OK)) begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = key_q;
            mem_req_o.wr_tag  = tag_q;
            if (hit_q) begin
              mem_req_o.wr_idx = hit_idx_q;
            end else begin
              mem_req_o.wr_idx = fill_q[stfl_pkg::IDX_W-1:0];
              fill_d           = fill_q + stfl_pkg::CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.status      = status_q;
    res_o.found_tag   = ((act_q == stfl_pkg::ACT_LOOKUP) && (status_q == stfl_pkg::ST_OK)) ?
                        stfl_pkg::RES_TAG_W'(best_tag_q) : '0;
    res_o.entry_count = stfl_pkg::COUNT_W'(fill_d);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rvld_q  <= rvld_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    key_q       <= key_d;
    tag_q       <= tag_d;
    idx_q       <= idx_d;
    ridx_q      <= ridx_d;
    have_q      <= have_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    best_addr_q <= best_addr_d;
    best_tag_q  <= best_tag_d;
    status_q    <= status_d;
  end

endmodule

// ----- hw/rtl/symbol_table_floor_lookup.sv -----
// Channel  | Dir | tdata (low bit up)                      | tuser
// s_axis   | in  | address[63:0], name_tag[95:64]          | action
// m_axis   | out | status[1:0], found_tag[33:2],           | -
//          |     | entry_count[41:34], zero pad [47:42]    |
// A lookup, and a register with no hit, scans all held entries through the single
// read port, one entry per cycle, before its result beat; a register hit at entry k
// ends the scan there, and an invalid item skips it. The next item is taken only
// once the result beat has left the sequencer.
// Reset clears the entry count; table contents need no clearing.
// s_axis_tready is high only while no item is in work; a result waiting on
// m_axis_tready holds the sequencer, a taken result frees it at once.
module symbol_table_floor_lookup (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [stfl_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // address, name_tag
  input  logic                               s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [stfl_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // status, found_tag, entry_count
);

  stfl_pkg::item_t    item;
  stfl_pkg::result_t  res;
  stfl_pkg::mem_req_t mem_req;
  stfl_pkg::entry_t   mem_rdata;
  logic               res_valid;
  logic               out_free;
  logic               in_valid;
  logic               in_ready;

  logic                              m_valid_q;
  logic [stfl_pkg::OUT_DATA_W-1:0]   m_data_q;

  // Unpack the input beat
  assign item.action   = s_axis_tuser;
  assign item.address  = s_axis_tdata[stfl_pkg::IN_ADDR_LSB +: stfl_pkg::ADDR_W];
  assign item.name_tag = s_axis_tdata[stfl_pkg::IN_TAG_LSB +: stfl_pkg::IN_TAG_W];
  assign in_valid      = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;

  stfl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .out_free_i  (out_free),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  stfl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      m_data_q <= {{(stfl_pkg::OUT_DATA_W - stfl_pkg::OUT_USED_W){1'b0}},
                   res.entry_count, res.found_tag, res.status};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- hw/rtl/stfl_checker.sv -----
`include "symbol_table_floor_lookup_defines.svh"

module stfl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [stfl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic                             in_beat;
  logic                             out_stall;
  logic                             not_ok;
  logic                             tag_zero;
  logic                             count_ok;
  logic [stfl_pkg::STATUS_W-1:0]    st;
  logic [stfl_pkg::RES_TAG_W-1:0]   ftag;
  logic [stfl_pkg::COUNT_W-1:0]     cnt;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign st        = m_axis_tdata[stfl_pkg::OUT_STATUS_LSB +: stfl_pkg::STATUS_W];
  assign ftag      = m_axis_tdata[stfl_pkg::OUT_TAG_LSB +: stfl_pkg::RES_TAG_W];
  assign cnt       = m_axis_tdata[stfl_pkg::OUT_COUNT_LSB +: stfl_pkg::COUNT_W];
  assign not_ok    = m_axis_tvalid && (st != stfl_pkg::ST_OK);
  assign tag_zero  = (ftag == '0);
  assign count_ok  = (32'(cnt) <= 32'(stfl_pkg::DEPTH));

  // block is busy after taking an item
  `STFL_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_beat, !s_axis_tready)
  // stalled result beat holds
  `STFL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  // no tag reported unless the item succeeded
  `STFL_ASSERT_IMP(a_tag_only_ok, clk_i, rst_ni, not_ok, tag_zero)
  // count never above table size
  `STFL_ASSERT_IMP(a_count_range, clk_i, rst_ni, m_axis_tvalid, count_ok)

endmodule

bind symbol_table_floor_lookup stfl_checker u_stfl_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import stfl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1040;
  localparam int unsigned IDLE_LIMIT   = 3000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 140;   // full-table scan plus overhead

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // address[63:0], name_tag[95:64]
  logic                  s_axis_tuser;   // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // status[1:0], found_tag[33:2], entry_count[41:34]

  // Set by the sender for stretches where neither side inserts gaps
  bit quiet;

  symbol_table_floor_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Mirror of the symbol table and the queue of expected lookup/register outcomes
  class symbol_scoreboard;
    logic [ADDR_W-1:0]    held_addr [DEPTH];
    logic [TAG_WIDTH-1:0] held_tag  [DEPTH];
    int unsigned          fill;
    result_t              pending_results [$];
    int unsigned          mismatches;

    function void note_item(logic action, logic [ADDR_W-1:0] addr, logic [IN_TAG_W-1:0] tag_in);
      logic [TAG_WIDTH-1:0] tag;
      result_t              res;
      bit                   hit;
      bit                   have;
      int unsigned          best;
      tag = TAG_WIDTH'(tag_in);
      res.status    = ST_OK;
      res.found_tag = '0;
      hit  = 0;
      have = 0;
      best = 0;
      if (action == ACT_REG) begin
        if (addr == '0 || tag == '0) begin
          res.status = ST_INVAL;
        end else begin
          // update in place on an equal address, else append
          for (int unsigned i = 0; i < fill; i++) begin
            if (!hit && held_addr[i] == addr) begin
              held_tag[i] = tag;
              hit = 1;
            end
          end
          if (!hit) begin
            if (fill >= DEPTH) begin
              res.status = ST_FULL;
            end else begin
              held_addr[fill] = addr;
              held_tag[fill]  = tag;
              fill++;
            end
          end
        end
      end else begin
        if (addr == '0) begin
          res.status = ST_INVAL;
        end else begin
          // greatest held address not above the query
          for (int unsigned i = 0; i < fill; i++) begin
            if (held_addr[i] <= addr && (!have || held_addr[i] > held_addr[best])) begin
              best = i;
              have = 1;
            end
          end
          if (have) res.found_tag = RES_TAG_W'(held_tag[best]);
          else res.status = ST_NOENT;
        end
      end
      res.entry_count = COUNT_W'(fill);
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] beat);
      result_t              want;
      logic [STATUS_W-1:0]  got_status;
      logic [RES_TAG_W-1:0] got_tag;
      logic [COUNT_W-1:0]   got_count;
      got_status = beat[OUT_STATUS_LSB +: STATUS_W];
      got_tag    = beat[OUT_TAG_LSB +: RES_TAG_W];
      got_count  = beat[OUT_COUNT_LSB +: COUNT_W];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", beat);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          mismatches++;
        end
        if (got_tag !== want.found_tag) begin
          $error("found_tag: expected %h, got %h", want.found_tag, got_tag);
          mismatches++;
        end
        if (got_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got_count);
          mismatches++;
        end
      end
    endfunction
  endclass

  symbol_scoreboard sb = new();

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One item per call; valid stays high into the next item when there is no gap
  task automatic send_item(input logic action, input logic [ADDR_W-1:0] addr,
                           input logic [IN_TAG_W-1:0] tag);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, addr};
    s_axis_tuser  <= action;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(action, addr, tag);
  endtask

  // Random item: well-formed traffic around held entries, plus some noise
  task automatic make_item(output logic action, output logic [ADDR_W-1:0] addr,
                           output logic [IN_TAG_W-1:0] tag);
    int unsigned          r;
    int unsigned          new_pct;
    logic [ADDR_W-1:0]    base;
    logic [ADDR_W-1:0]    delta;
    r       = $urandom_range(0, 99);
    new_pct = (sb.fill >= DEPTH) ? 10 : 30;
    tag     = $urandom;
    if (tag == '0) tag = 1;
    base  = (sb.fill > 0) ? sb.held_addr[$urandom_range(0, sb.fill - 1)] : {$urandom, $urandom};
    delta = ADDR_W'($urandom_range(1, 3));
    if (r < new_pct) begin
      // new address, either anywhere or clustered in a small range
      action = ACT_REG;
      addr   = $urandom_range(0, 1) ? {$urandom, $urandom} : ADDR_W'($urandom_range(1, 65535));
    end else if (r < new_pct + 15) begin
      // tag update of a held address
      action = ACT_REG;
      addr   = base;
    end else if (r < 80) begin
      // lookup at, just above or just below a held address
      action = ACT_LOOKUP;
      case ($urandom_range(0, 2))
        0:       addr = base;
        1:       addr = base + delta;
        default: addr = base - delta;
      endcase
    end else if (r < 90) begin
      action = ACT_LOOKUP;
      addr   = {$urandom, $urandom};
    end else begin
      // invalid: zero address on either action, or zero tag on register
      action = $urandom_range(0, 1) ? ACT_LOOKUP : ACT_REG;
      addr   = {$urandom, $urandom};
      if (action == ACT_LOOKUP || $urandom_range(0, 1)) addr = '0;
      else tag = '0;
    end
  endtask

  // Stimulus
  initial begin
    logic                 action;
    logic [ADDR_W-1:0]    addr;
    logic [IN_TAG_W-1:0]  tag;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_REG;
    quiet         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, invalid inputs, extremes, update, floor edges
    send_item(ACT_LOOKUP, 64'd5, 32'd0);
    send_item(ACT_REG, 64'd0, 32'd1);
    send_item(ACT_REG, 64'h10, 32'd0);
    send_item(ACT_LOOKUP, 64'd0, 32'hFFFF_FFFF);
    send_item(ACT_REG, 64'h1000, 32'hFFFF_FFFF);
    send_item(ACT_REG, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    send_item(ACT_REG, 64'd1, 32'hA5A5_5A5A);
    send_item(ACT_REG, 64'h1000, 32'h0000_1234);
    send_item(ACT_LOOKUP, 64'h1000, 32'hDEAD_BEEF);
    send_item(ACT_LOOKUP, 64'h0FFF, 32'd0);
    send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0);
    send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(ACT_LOOKUP, 64'd1, 32'd0);
    send_item(ACT_REG, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_item(ACT_LOOKUP, 64'h8000_0000_0000_0001, 32'd0);
    send_item(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0);

    // random traffic; fills the table, then keeps hitting it while full
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 150) % 3) == 2;
      make_item(action, addr, tag);
      send_item(action, addr, tag);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    // drain, then allow a full scan for stray beats
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: check taken beats, stall at random
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (stall > 0 && !quiet) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Watchdog on cycles without any beat
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

// ----- symbol_table_floor_lookup.f -----
+incdir+hw/rtl
hw/rtl/stfl_pkg.sv
hw/rtl/stfl_mem.sv
hw/rtl/stfl_seq.sv
hw/rtl/symbol_table_floor_lookup.sv
hw/rtl/stfl_checker.sv
tb/sv/testbench.sv
